// File: design/spi_pkg.sv
// Package with shared constants and types for the segment point interpolator.
`default_nettype none
package spi_pkg;
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int SQ_W      = 50;
  localparam int LEN_W     = 25;
  localparam int DMAG_W    = 25;
  localparam int MAX_POINTS_DEF = 63;
  localparam logic [RAD_W-1:0] SPACING_RST = 23'd256;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAD_W-1:0]          rad_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    rad_t   r;
  } point_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// File: design/spi_if.sv
// Valid/ready channel interfaces for input segments, output points and configuration.
`default_nettype none
interface spi_seg_if (input wire logic clk);
  import spi_pkg::*;
  logic   valid;
  logic   ready;
  point_t start_pt;
  point_t end_pt;
  logic   is_soma;
  modport source (output valid, start_pt, end_pt, is_soma, input ready);
  modport sink (input valid, start_pt, end_pt, is_soma, output ready);
endinterface

interface spi_pt_if (input wire logic clk);
  import spi_pkg::*;
  logic   valid;
  logic   ready;
  point_t pt;
  logic   last_point;
  modport source (output valid, pt, last_point, input ready);
  modport sink (input valid, pt, last_point, output ready);
endinterface

interface spi_cfg_if (input wire logic clk);
  import spi_pkg::*;
  logic valid;
  logic ready;
  rad_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: design/spi_div.sv
// Shared restoring divider, one quotient bit per cycle, also used for the square root.
`default_nettype none
module spi_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic         sqrt_mode,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              busy,
  output logic [W-1:0]      quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem_r, rem_nxt, q_r, q_nxt, n_r, n_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, sq_r;
  logic [W+1:0]  trial, sub;
  logic [W+1:0]  rsh;

  assign busy = busy_r;
  assign quo  = q_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    n_nxt    = n_r;
    trial    = '0;
    sub      = '0;
    rsh      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      q_nxt    = '0;
      n_nxt    = num;
      cnt_nxt  = sqrt_mode ? CW'(W / 2) : CW'(W);
    end else if (busy_r) begin
      if (sq_r) begin
        rsh   = {rem_r, n_r[W-1:W-2]};
        trial = {2'b00, q_r[W-3:0], 2'b01};
        sub   = rsh - trial;
        n_nxt = {n_r[W-3:0], 2'b00};
        if (!sub[W+1]) begin
          rem_nxt = sub[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
      end else begin
        rsh   = {1'b0, rem_r, n_r[W-1]};
        sub   = rsh - {2'b00, d_r};
        n_nxt = {n_r[W-2:0], 1'b0};
        if (!sub[W+1]) begin
          rem_nxt = sub[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    n_r   <= n_nxt;
    if (start) begin
      d_r  <= den;
      sq_r <= sqrt_mode;
    end
  end
endmodule
`default_nettype wire

// File: design/spi_seq.sv
// Sequencer that steps one segment through length, count and interior point generation.
`default_nettype none
module spi_seq #(
  parameter int MAX_POINTS = spi_pkg::MAX_POINTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spi_seg_if.sink    seg,
  spi_pt_if.source   pts,
  input  wire spi_pkg::rad_t spacing
);
  import spi_pkg::*;
  localparam int W  = SQ_W + 2;
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_SQW   = 9'b000000100,
    S_NDIV  = 9'b000001000,
    S_NW    = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DW    = 9'b100000000
  } state_t;

  state_t state_r;
  point_t sp_r, ep_r, out_pt_r;
  logic   soma_r, ov_r, olast_r;
  logic [DMAG_W-1:0] mag_r [4];
  logic              neg_r [4];
  logic [1:0]        lane_r;
  logic [2:0]        phase_r;
  logic [NW-1:0]     n_r, i_r;
  logic [W-1:0]      acc_r, num_mux, den_mux, quo;
  logic              dstart, dsq, dbusy;
  logic [DMAG_W-1:0] q_r [4];
  logic signed [DMAG_W:0] d_full [4];
  logic [DMAG_W-1:0] mag_c;
  logic [DMAG_W-1:0] mul_b;
  logic [2*DMAG_W-1:0] prod;
  div_ctl_t ctl;

  spi_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .sqrt_mode(dsq),
    .num(num_mux), .den(den_mux), .busy(dbusy), .quo(quo)
  );

  assign ctl = '{start: dstart, busy: dbusy, done: 1'b0};
  assign seg.ready = (state_r == S_IDLE) && !ov_r;
  assign pts.valid = ov_r;
  assign pts.pt = out_pt_r;
  assign pts.last_point = olast_r;

  always_comb begin
    d_full[0] = (DMAG_W+1)'(signed'(seg.end_pt.x)) - (DMAG_W+1)'(signed'(seg.start_pt.x));
    d_full[1] = (DMAG_W+1)'(signed'(seg.end_pt.y)) - (DMAG_W+1)'(signed'(seg.start_pt.y));
    d_full[2] = (DMAG_W+1)'(signed'(seg.end_pt.z)) - (DMAG_W+1)'(signed'(seg.start_pt.z));
    d_full[3] = $signed({3'b000, seg.end_pt.r}) - $signed({3'b000, seg.start_pt.r});
  end

  always_comb begin
    mag_c = mag_r[lane_r];
    mul_b = (state_r == S_MUL) ? mag_c : {{(DMAG_W-NW){1'b0}}, i_r};
    prod  = mag_c * mul_b;
    dsq = (state_r == S_SQ);
    dstart = (state_r == S_SQ) || (state_r == S_NDIV) || (state_r == S_DIV);
    num_mux = (state_r == S_DIV) ? W'(prod) : acc_r;
    den_mux = (state_r == S_NDIV) ? W'(spacing) : W'(n_r);
  end

  function automatic coord_t addc(coord_t b, logic [DMAG_W-1:0] q, logic ng);
    logic [DMAG_W-1:0] s;
    s = ng ? (DMAG_W'(signed'(b)) - q) : (DMAG_W'(signed'(b)) + q);
    return s[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (pts.valid && pts.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (seg.valid && seg.ready) begin
            sp_r <= seg.start_pt;
            ep_r <= seg.end_pt;
            soma_r <= seg.is_soma;
            for (int k = 0; k < 4; k++) begin
              neg_r[k] <= d_full[k][DMAG_W];
              mag_r[k] <= d_full[k][DMAG_W] ? DMAG_W'(-d_full[k]) : d_full[k][DMAG_W-1:0];
            end
            lane_r  <= '0;
            acc_r   <= '0;
            phase_r <= '0;
            out_pt_r <= seg.start_pt;
            olast_r <= 1'b0;
            ov_r    <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (phase_r == 3'd3) begin
            state_r <= S_SQ;
          end else begin
            acc_r <= acc_r + W'(prod);
            lane_r <= lane_r + 2'd1;
            phase_r <= phase_r + 3'd1;
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (!dbusy && !ctl.start) begin
            acc_r <= W'(quo[LEN_W-1:0]);
            if (spacing == '0) begin
              n_r <= NW'(MAX_POINTS);
              state_r <= S_EMIT;
            end else begin
              state_r <= S_NDIV;
            end
          end
        end
        S_NDIV: state_r <= S_NW;
        S_NW: begin
          if (!dbusy && !ctl.start) begin
            n_r <= (quo > W'(MAX_POINTS)) ? NW'(MAX_POINTS) : quo[NW-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ov_r) begin
            out_pt_r <= ep_r;
            ov_r <= 1'b1;
            if (soma_r || n_r <= NW'(2)) begin
              olast_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              olast_r <= 1'b0;
              i_r <= NW'(1);
              lane_r <= '0;
              phase_r <= 3'd4;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          state_r <= S_DW;
        end
        S_DW: begin
          if (!dbusy && !ctl.start) begin
            q_r[lane_r] <= quo[DMAG_W-1:0];
            if (lane_r == 2'd3) begin
              if (!ov_r) begin
                out_pt_r.x <= addc(sp_r.x, q_r[0], neg_r[0]);
                out_pt_r.y <= addc(sp_r.y, q_r[1], neg_r[1]);
                out_pt_r.z <= addc(sp_r.z, q_r[2], neg_r[2]);
                out_pt_r.r <= neg_r[3] ? (sp_r.r - quo[RAD_W-1:0]) : (sp_r.r + quo[RAD_W-1:0]);
                olast_r <= (i_r == n_r - NW'(1));
                ov_r <= 1'b1;
                lane_r <= '0;
                if (i_r == n_r - NW'(1)) begin
                  state_r <= S_IDLE;
                end else begin
                  i_r <= i_r + NW'(1);
                  state_r <= S_DIV;
                end
              end
            end else begin
              lane_r <= lane_r + 2'd1;
              state_r <= S_DIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/segment_point_interpolator.sv
// Top level of the segment point interpolator.
// The start point is shown the cycle after the beat is taken; the end point follows the sum of squares,
// the square root and the count division (skipped at zero spacing). Each interior point takes four
// shared-divider passes, one per lane. A new segment is taken only once the last point has gone out.
// The single bit-serial divider also does the square root.
// Synchronous active-low reset clears the sequencer and sets point_spacing to 1.0.
`default_nettype none
module segment_point_interpolator #(
  parameter int MAX_POINTS = spi_pkg::MAX_POINTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  spi_seg_if.sink  in_seg,
  spi_pt_if.source out_pt,
  spi_cfg_if.sink  cfg
);
  import spi_pkg::*;
  rad_t spacing_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
    end else if (cfg.valid && cfg.ready) begin
      spacing_r <= cfg.data;
    end
  end

  spi_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
    .clk(clk), .rst_n(rst_n), .seg(in_seg), .pts(out_pt), .spacing(spacing_r)
  );
endmodule
`default_nettype wire

// File: design/spi_checker.sv
// Port-level checker for the segment point interpolator and its bind.
`default_nettype none
module spi_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");
  a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_valid && !out_last))
    else $error("start point missing after accept");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind segment_point_interpolator spi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_seg.valid), .in_ready(in_seg.ready),
  .out_valid(out_pt.valid), .out_ready(out_pt.ready), .out_last(out_pt.last_point)
);
`default_nettype wire

// File: sim/segment_point_interpolator_chk.sv
// Checker that predicts the points of each segment beat and compares the output beats.
`timescale 1ns / 1ps
module segment_point_interpolator_chk (
  input  wire logic clk,
  input  wire logic rst_n,
  spi_seg_if        seg,
  spi_pt_if         pts,
  spi_cfg_if        cfg,
  output int        fail_count,
  output int        pending
);
  import spi_pkg::*;
  localparam int MAXN = MAX_POINTS_DEF;

  typedef struct packed {
    point_t pt;
    logic   last;
  } due_pt_t;

  due_pt_t points_due[$];
  longint  spacing_now;

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint step_part(longint d, longint i, longint n);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag * i) / n;
    return (d < 0) ? -q : q;
  endfunction

  task automatic predict_points(input point_t s, input point_t e, input logic soma);
    longint  dx, dy, dz, dr, len, n, i;
    logic    interior;
    due_pt_t d;
    dx = longint'(e.x) - longint'(s.x);
    dy = longint'(e.y) - longint'(s.y);
    dz = longint'(e.z) - longint'(s.z);
    dr = longint'(e.r) - longint'(s.r);
    len = root_floor(dx * dx + dy * dy + dz * dz);
    if (spacing_now == 0) begin
      n = MAXN;
    end else begin
      n = len / spacing_now;
      if (n > MAXN) n = MAXN;
    end
    interior = !soma && n > 2;
    d.pt = s;
    d.last = 1'b0;
    points_due = {points_due, d};
    d.pt = e;
    d.last = !interior;
    points_due = {points_due, d};
    if (interior) begin
      for (i = 1; i < n; i++) begin
        d.pt.x = coord_t'(longint'(s.x) + step_part(dx, i, n));
        d.pt.y = coord_t'(longint'(s.y) + step_part(dy, i, n));
        d.pt.z = coord_t'(longint'(s.z) + step_part(dz, i, n));
        d.pt.r = rad_t'(longint'(s.r) + step_part(dr, i, n));
        d.last = (i == n - 1);
        points_due = {points_due, d};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    due_pt_t w;
    if (!rst_n) begin
      spacing_now = SPACING_RST;
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) spacing_now = cfg.data;
      if (seg.valid && seg.ready) predict_points(seg.start_pt, seg.end_pt, seg.is_soma);
      if (pts.valid && pts.ready) begin
        if (points_due.size() == 0) begin
          report_mismatch("unexpected point beat", 1, 0);
        end else begin
          w = points_due.pop_front();
          if (pts.pt.x !== w.pt.x) report_mismatch("point_x", pts.pt.x, w.pt.x);
          if (pts.pt.y !== w.pt.y) report_mismatch("point_y", pts.pt.y, w.pt.y);
          if (pts.pt.z !== w.pt.z) report_mismatch("point_z", pts.pt.z, w.pt.z);
          if (pts.pt.r !== w.pt.r) report_mismatch("point_radius", pts.pt.r, w.pt.r);
          if (pts.last_point !== w.last) report_mismatch("last_point", pts.last_point, w.last);
        end
      end
    end
    pending = points_due.size();
  end
endmodule

// File: sim/segment_point_interpolator_tb.sv
// Testbench top: drives segments and spacing settings, stalls the output, and reports.
`timescale 1ns / 1ps
module segment_point_interpolator_tb;
  import spi_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   out_beats;

  spi_seg_if seg (.clk(clk));
  spi_pt_if  pts (.clk(clk));
  spi_cfg_if cfg (.clk(clk));

  segment_point_interpolator dut (
    .clk(clk), .rst_n(rst_n), .in_seg(seg.sink), .out_pt(pts.source), .cfg(cfg.sink)
  );

  segment_point_interpolator_chk chk (
    .clk(clk), .rst_n(rst_n), .seg(seg), .pts(pts), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (seg.valid && seg.ready) || (pts.valid && pts.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("segment_point_interpolator_tb: FAIL");
      $finish;
    end
  end

  // Output side: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int gap;
    pts.ready = 1'b0;
    out_beats = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ((out_beats / 64) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (out_beats == 120) gap = 600;
      if (gap > 0) begin
        pts.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pts.ready <= 1'b1;
      do @(posedge clk); while (!pts.valid);
      out_beats++;
    end
  end

  task automatic write_spacing(input rad_t v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_segment(input point_t s, input point_t e, input logic soma,
                              input logic quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      seg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg.valid <= 1'b1;
    seg.start_pt <= s;
    seg.end_pt <= e;
    seg.is_soma <= soma;
    do @(posedge clk); while (!seg.ready);
  endtask

  function automatic point_t full_point();
    point_t p;
    p.x = coord_t'($urandom);
    p.y = coord_t'($urandom);
    p.z = coord_t'($urandom);
    p.r = rad_t'($urandom);
    return p;
  endfunction

  function automatic point_t near_point(input point_t s, input int reach);
    point_t p;
    p.x = s.x + coord_t'($urandom_range(0, 2 * reach) - reach);
    p.y = s.y + coord_t'($urandom_range(0, 2 * reach) - reach);
    p.z = s.z + coord_t'($urandom_range(0, 2 * reach) - reach);
    p.r = rad_t'($urandom);
    return p;
  endfunction

  function automatic point_t mk(input int x, input int y, input int z, input int r);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.r = rad_t'(r);
    return p;
  endfunction

  initial begin
    point_t s;
    point_t e;
    int     sp;
    int     k;
    int     reach;
    logic   quiet;
    rst_n = 1'b0;
    seg.valid = 1'b0;
    seg.start_pt = '0;
    seg.end_pt = '0;
    seg.is_soma = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed segments at the reset spacing of 1.0.
    send_segment(mk(0, 0, 0, 0), mk(0, 0, 0, 0), 1'b0, 1'b0);
    send_segment(mk(0, 0, 0, 0), mk(512, 0, 0, 256), 1'b0, 1'b0);
    send_segment(mk(0, 0, 0, 0), mk(768, 0, 0, 8388607), 1'b0, 1'b0);
    send_segment(mk(100, 200, -300, 8388607), mk(-900, 1200, 700, 0), 1'b0, 1'b0);
    send_segment(mk(100, 200, -300, 5), mk(-900, 1200, 700, 0), 1'b1, 1'b0);
    send_segment(mk(-8388608, -8388608, -8388608, 0),
                 mk(8388607, 8388607, 8388607, 8388607), 1'b0, 1'b0);
    send_segment(mk(8388607, -8388608, 0, 8388607), mk(-8388608, 8388607, 0, 0), 1'b1, 1'b0);
    send_segment(mk(0, 0, 0, 1000), mk(-1300, -10, 7, 10), 1'b0, 1'b0);
    seg.valid <= 1'b0;

    // Zero spacing saturates the count.
    write_spacing(rad_t'(0));
    send_segment(mk(0, 0, 0, 0), mk(0, 0, 0, 0), 1'b0, 1'b0);
    send_segment(mk(5, -5, 9, 3), mk(-70, 80, 90, 4000), 1'b0, 1'b0);
    send_segment(mk(5, -5, 9, 3), mk(-70, 80, 90, 4000), 1'b1, 1'b0);
    seg.valid <= 1'b0;

    // Smallest nonzero spacing.
    write_spacing(rad_t'(1));
    send_segment(full_point(), full_point(), 1'b0, 1'b0);
    send_segment(mk(0, 0, 0, 0), mk(2, 0, 0, 0), 1'b0, 1'b0);
    send_segment(mk(0, 0, 0, 0), mk(0, 3, 0, 9), 1'b0, 1'b0);
    seg.valid <= 1'b0;

    // Largest spacing with full-range coordinates.
    write_spacing(rad_t'(8388607));
    for (k = 0; k < 150; k++) begin
      quiet = ((k / 32) % 2) == 1;
      send_segment(full_point(), full_point(), $urandom_range(0, 3) == 0, quiet);
    end
    seg.valid <= 1'b0;

    // Random spacings with segments a few spacings long.
    for (k = 0; k < 340; k++) begin
      if (k % 60 == 0) begin
        seg.valid <= 1'b0;
        sp = $urandom_range(16, 4096);
        write_spacing(rad_t'(sp));
      end
      reach = sp * $urandom_range(1, 4);
      s = full_point();
      s.x = coord_t'($urandom_range(0, 16000000) - 8000000);
      s.y = coord_t'($urandom_range(0, 16000000) - 8000000);
      s.z = coord_t'($urandom_range(0, 16000000) - 8000000);
      e = near_point(s, reach);
      quiet = ((k / 40) % 2) == 1;
      if ($urandom_range(0, 9) == 0) e = s;
      send_segment(s, e, $urandom_range(0, 7) == 0, quiet);
    end
    seg.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("segment_point_interpolator_tb: PASS");
    end else begin
      $display("segment_point_interpolator_tb: FAIL");
    end
    $finish;
  end
endmodule
